### rtl/edf_pkg.sv
// Package with shared constants, types and the controller state encoding.
package edf_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN1,
        ST_PICK,
        ST_SCAN2,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             load;
        logic             scan1;
        logic             pick;
        logic             scan2;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic out_free;
    } sts_t;

endpackage

### rtl/edf_ctrl.sv
// Controller state machine that sequences load and tick handling.
module edf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  edf_pkg::sts_t sts,
    output edf_pkg::cmd_t cmd
);

    edf_pkg::state_t              state_reg;
    edf_pkg::state_t              state_next;
    logic [edf_pkg::IDX_W-1:0]    idx_reg;
    logic [edf_pkg::IDX_W-1:0]    idx_next;
    logic                         last_idx;

    assign last_idx = (idx_reg == edf_pkg::IDX_W'(edf_pkg::MAX_TASKS - 1));

    // State and slot counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edf_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state logic.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            edf_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                    state_next = edf_pkg::ST_LOAD;
            end
            edf_pkg::ST_LOAD:
            begin
                state_next = sts.is_tick ? edf_pkg::ST_SCAN1 : edf_pkg::ST_FIN;
            end
            edf_pkg::ST_SCAN1:
            begin
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = edf_pkg::ST_PICK;
                end
            end
            edf_pkg::ST_PICK:
            begin
                state_next = edf_pkg::ST_SCAN2;
            end
            edf_pkg::ST_SCAN2:
            begin
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = edf_pkg::ST_FIN;
                end
            end
            edf_pkg::ST_FIN:
            begin
                if (sts.out_free)
                    state_next = edf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = edf_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        cmd.idx  = idx_reg;
        in_stall = 1'b1;
        case (state_reg)
            edf_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            edf_pkg::ST_LOAD:  cmd.load  = !sts.is_tick;
            edf_pkg::ST_SCAN1: cmd.scan1 = 1'b1;
            edf_pkg::ST_PICK:  cmd.pick  = 1'b1;
            edf_pkg::ST_SCAN2: cmd.scan2 = 1'b1;
            edf_pkg::ST_FIN:   cmd.finish = sts.out_free;
            default:           cmd = '0;
        endcase
    end

    // Only one datapath operation is commanded at a time.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.load, cmd.scan1, cmd.pick, cmd.scan2, cmd.finish}))
        else $error("more than one datapath command");

endmodule

### rtl/edf_dp.sv
// Datapath with the task tables, scan logic, counters and result register.
module edf_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  edf_pkg::cmd_t cmd,
    output edf_pkg::sts_t sts,
    input  logic          req_type,
    input  logic [3:0]    slot,
    input  logic [31:0]   task_arrival,
    input  logic [15:0]   task_period,
    input  logic [15:0]   task_burst,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          ran_valid,
    output logic [3:0]    ran_slot,
    output logic          ran_done,
    output logic [4:0]    misses_this_tick,
    output logic [31:0]   busy_ticks,
    output logic [31:0]   time_now
);

    localparam int N = edf_pkg::MAX_TASKS;
    localparam int W = edf_pkg::IDX_W;

    // Task tables.
    logic          valid_reg   [N];
    logic [15:0]   miss_reg    [N];
    logic [31:0]   arr_tab_reg [N];
    logic [15:0]   per_tab_reg [N];
    logic [15:0]   bur_tab_reg [N];
    logic [15:0]   rem_tab_reg [N];
    logic [31:0]   dl_tab_reg  [N];

    // Captured request.
    logic          tick_reg;
    logic [3:0]    slot_reg;
    logic [31:0]   arr_in_reg;
    logic [15:0]   per_in_reg;
    logic [15:0]   bur_in_reg;

    // Scheduler state and per-tick results.
    logic [31:0]   now_reg;
    logic [31:0]   busy_reg;
    logic          running_reg;
    logic          best_v_reg;
    logic [W-1:0]  best_idx_reg;
    logic [31:0]   best_dl_reg;
    logic          ran_v_reg;
    logic          ran_d_reg;
    logic [4:0]    misses_reg;

    // Result word register.
    logic          out_v_reg;
    logic          o_ran_v_reg;
    logic [3:0]    o_slot_reg;
    logic          o_done_reg;
    logic [4:0]    o_miss_reg;
    logic [31:0]   o_busy_reg;
    logic [31:0]   o_time_reg;

    logic          slot_ok;
    logic [W-1:0]  addr;
    logic          a_val;
    logic [31:0]   a_arr;
    logic [15:0]   a_per;
    logic [15:0]   a_bur;
    logic [15:0]   a_rem;
    logic [31:0]   a_dl;
    logic          rel;
    logic [31:0]   d_eff;
    logic          elig;
    logic [15:0]   rem_dec;
    logic          due;
    logic          miss_hit;

    assign slot_ok = (32'(slot_reg) < N);

    // One table address per cycle: the load slot, the picked slot or the scan index.
    always_comb
    begin
        if (cmd.load)
            addr = W'(slot_reg);
        else if (cmd.pick)
            addr = best_idx_reg;
        else
            addr = cmd.idx;
    end

    assign a_val = valid_reg[addr];
    assign a_arr = arr_tab_reg[addr];
    assign a_per = per_tab_reg[addr];
    assign a_bur = bur_tab_reg[addr];
    assign a_rem = rem_tab_reg[addr];
    assign a_dl  = dl_tab_reg[addr];

    // Release and selection terms for the first scan.
    assign rel     = a_val && (a_arr == now_reg);
    assign d_eff   = rel ? (a_arr + 32'(a_per)) : a_dl;
    assign elig    = a_val && (a_arr <= now_reg) && (a_rem != 16'd0);
    assign rem_dec = a_rem - 16'd1;

    // Deadline terms for the second scan.
    assign due      = a_val && (a_dl == now_reg);
    assign miss_hit = due && (a_arr <= now_reg) && (a_rem != 16'd0);

    // Table contents that need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            arr_tab_reg[addr] <= arr_in_reg;
            per_tab_reg[addr] <= per_in_reg;
            bur_tab_reg[addr] <= bur_in_reg;
            rem_tab_reg[addr] <= bur_in_reg;
            dl_tab_reg[addr]  <= arr_in_reg + 32'(per_in_reg);
        end
        if (cmd.scan1 && rel)
            dl_tab_reg[addr] <= d_eff;
        if (cmd.pick && best_v_reg)
            rem_tab_reg[addr] <= rem_dec;
        if (cmd.scan2 && due)
        begin
            rem_tab_reg[addr] <= a_bur;
            dl_tab_reg[addr]  <= now_reg + 32'(a_per);
        end
    end

    // Captured request fields.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tick_reg   <= req_type;
            slot_reg   <= slot;
            arr_in_reg <= task_arrival;
            per_in_reg <= task_period;
            bur_in_reg <= task_burst;
        end
    end

    // Control state: valid bits, miss counters, time, busy count and scan results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
                miss_reg[i]  <= '0;
            end
            now_reg      <= '0;
            busy_reg     <= '0;
            running_reg  <= 1'b0;
            best_v_reg   <= 1'b0;
            best_idx_reg <= '0;
            best_dl_reg  <= '0;
            ran_v_reg    <= 1'b0;
            ran_d_reg    <= 1'b0;
            misses_reg   <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                best_v_reg   <= 1'b0;
                best_idx_reg <= '0;
                ran_v_reg    <= 1'b0;
                ran_d_reg    <= 1'b0;
                misses_reg   <= '0;
            end
            if (cmd.load && slot_ok)
            begin
                valid_reg[addr] <= 1'b1;
                miss_reg[addr]  <= '0;
            end
            if (cmd.scan1 && elig && (!best_v_reg || (d_eff < best_dl_reg)))
            begin
                best_v_reg   <= 1'b1;
                best_idx_reg <= addr;
                best_dl_reg  <= d_eff;
            end
            if (cmd.pick)
            begin
                if (running_reg && (busy_reg != 32'hFFFF_FFFF))
                    busy_reg <= busy_reg + 32'd1;
                ran_v_reg   <= best_v_reg;
                ran_d_reg   <= best_v_reg && (rem_dec == 16'd0);
                running_reg <= best_v_reg && (rem_dec != 16'd0);
            end
            if (cmd.scan2 && miss_hit)
            begin
                misses_reg <= misses_reg + 5'd1;
                if (miss_reg[addr] != 16'hFFFF)
                    miss_reg[addr] <= miss_reg[addr] + 16'd1;
            end
            if (cmd.finish && tick_reg)
                now_reg <= now_reg + 32'd1;
        end
    end

    // Result word valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (cmd.finish)
            out_v_reg <= 1'b1;
        else if (!out_stall)
            out_v_reg <= 1'b0;
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            o_ran_v_reg <= ran_v_reg;
            o_slot_reg  <= ran_v_reg ? 4'(best_idx_reg) : 4'd0;
            o_done_reg  <= ran_d_reg;
            o_miss_reg  <= misses_reg;
            o_busy_reg  <= busy_reg;
            o_time_reg  <= now_reg;
        end
    end

    assign sts.is_tick  = tick_reg;
    assign sts.out_free = !out_v_reg || !out_stall;

    assign out_valid        = out_v_reg;
    assign ran_valid        = o_ran_v_reg;
    assign ran_slot         = o_slot_reg;
    assign ran_done         = o_done_reg;
    assign misses_this_tick = o_miss_reg;
    assign busy_ticks       = o_busy_reg;
    assign time_now         = o_time_reg;

    // A running task implies a task ran and did not finish on the last tick.
    a_running: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (ran_v_reg && !ran_d_reg) || !$past(cmd.pick))
        else $error("running flag without an unfinished run");

    // Busy count never moves backward.
    a_busy_mono: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg >= $past(busy_reg))
        else $error("busy count decreased");

    // Misses in one tick cannot exceed the number of slots.
    a_miss_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(misses_reg) <= N)
        else $error("miss count exceeds slot count");

endmodule

### rtl/edf_periodic_task_scheduler.sv
// Top level of the earliest-deadline-first periodic task scheduler.
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_stall    req_type, slot, task_arrival, task_period,
//                                              task_burst
//   out       output      out_valid/out_stall  ran_valid, ran_slot, ran_done,
//                                              misses_this_tick, busy_ticks, time_now
//
// A load's result word is registered after the LOAD and FIN states, a tick's after LOAD, a
// SCAN1 pass, PICK, a SCAN2 pass and FIN, the two passes using one shared table port over all
// slots. The block returns to IDLE before it takes the next word, so words do not overlap; a new
// word is taken while the previous result still waits in the output register.
// Reset clears time, valid bits, miss counters and the busy count at once.
// A stalled result holds the block in its final state until it is taken.
module edf_periodic_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  slot,
    input  logic [31:0] task_arrival,
    input  logic [15:0] task_period,
    input  logic [15:0] task_burst,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ran_valid,
    output logic [3:0]  ran_slot,
    output logic        ran_done,
    output logic [4:0]  misses_this_tick,
    output logic [31:0] busy_ticks,
    output logic [31:0] time_now
);

    edf_pkg::cmd_t cmd;
    edf_pkg::sts_t sts;

    // Sequencer.
    edf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Tables and arithmetic.
    edf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .req_type         (req_type),
        .slot             (slot),
        .task_arrival     (task_arrival),
        .task_period      (task_period),
        .task_burst       (task_burst),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .ran_valid        (ran_valid),
        .ran_slot         (ran_slot),
        .ran_done         (ran_done),
        .misses_this_tick (misses_this_tick),
        .busy_ticks       (busy_ticks),
        .time_now         (time_now)
    );

endmodule

### test/tb_edf_periodic_task_scheduler.sv
// Testbench for the EDF periodic task scheduler: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_edf_periodic_task_scheduler;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic        ran_done;
        logic [4:0]  misses_this_tick;
        logic [31:0] busy_ticks;
        logic [31:0] time_now;
    } sched_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [3:0]  slot;
    logic [31:0] task_arrival;
    logic [15:0] task_period;
    logic [15:0] task_burst;
    logic        out_valid;
    logic        out_stall;
    logic        ran_valid;
    logic [3:0]  ran_slot;
    logic        ran_done;
    logic [4:0]  misses_this_tick;
    logic [31:0] busy_ticks;
    logic [31:0] time_now;

    // Predictor state.
    logic [31:0] now_tick;
    logic        task_live [edf_pkg::MAX_TASKS];
    logic [31:0] task_arr [edf_pkg::MAX_TASKS];
    logic [15:0] task_per [edf_pkg::MAX_TASKS];
    logic [15:0] task_bur [edf_pkg::MAX_TASKS];
    logic [15:0] work_left [edf_pkg::MAX_TASKS];
    logic [31:0] task_dl [edf_pkg::MAX_TASKS];
    logic [15:0] miss_cnt [edf_pkg::MAX_TASKS];
    logic        still_running;
    logic [31:0] busy_count;

    sched_out_t  pending_results [$];
    int          errors;
    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] base_tick;

    edf_periodic_task_scheduler i_dut (.*);

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bound on the whole run.
    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    // Work out the result word of one accepted input word.
    function automatic sched_out_t schedule_word(logic rt, logic [3:0] s, logic [31:0] arr,
                                                 logic [15:0] per, logic [15:0] bur);
        sched_out_t r;
        int         pick;
        r = '0;
        r.time_now = now_tick;
        pick = -1;
        if (rt == REQ_LOAD)
        begin
            task_live[s] = 1'b1;
            task_arr[s]  = arr;
            task_per[s]  = per;
            task_bur[s]  = bur;
            work_left[s] = bur;
            task_dl[s]   = arr + 32'(per);
            miss_cnt[s]  = '0;
        end
        else
        begin
            if (still_running && busy_count != 32'hFFFF_FFFF)
                busy_count++;
            // Release tasks arriving now.
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++)
                if (task_live[i] && task_arr[i] == now_tick)
                    task_dl[i] = task_arr[i] + 32'(task_per[i]);
            // Earliest deadline among ready tasks, lowest slot on ties.
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++)
            begin
                if (!task_live[i] || task_arr[i] > now_tick || work_left[i] == 0)
                    continue;
                if (pick < 0 || task_dl[i] < task_dl[pick])
                    pick = i;
            end
            if (pick >= 0)
            begin
                work_left[pick]--;
                r.ran_valid = 1'b1;
                r.ran_slot  = 4'(pick);
                r.ran_done  = (work_left[pick] == 0);
            end
            still_running = r.ran_valid && !r.ran_done;
            // Deadline handling.
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++)
            begin
                if (!task_live[i] || task_dl[i] != now_tick)
                    continue;
                if (task_arr[i] <= now_tick && work_left[i] > 0)
                begin
                    if (miss_cnt[i] != 16'hFFFF)
                        miss_cnt[i]++;
                    r.misses_this_tick++;
                end
                work_left[i] = task_bur[i];
                task_dl[i]   = now_tick + 32'(task_per[i]);
            end
            now_tick++;
        end
        r.busy_ticks = busy_count;
        return r;
    endfunction

    // Send one word and record its expected result once it is accepted.
    task automatic send_word(logic rt, logic [3:0] s, logic [31:0] arr,
                             logic [15:0] per, logic [15:0] bur);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rt;
        slot         <= s;
        task_arrival <= arr;
        task_period  <= per;
        task_burst   <= bur;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), schedule_word(rt, s, arr, per, bur));
    endtask

    task automatic send_tick();
        send_word(REQ_TICK, 4'($urandom), $urandom, 16'($urandom), 16'($urandom));
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        sched_out_t got;
        sched_out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {ran_valid, ran_slot, ran_done, misses_this_tick, busy_ticks, time_now};
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $realtime, got);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.ran_valid !== exp_r.ran_valid || got.ran_slot !== exp_r.ran_slot ||
                    got.ran_done !== exp_r.ran_done ||
                    got.misses_this_tick !== exp_r.misses_this_tick ||
                    got.busy_ticks !== exp_r.busy_ticks || got.time_now !== exp_r.time_now)
                begin
                    $display("%0t mismatch expected %h actual %h", $realtime, exp_r, got);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Directed: extremes of the fields, ties, zero work, misses.
    task automatic test_directed();
        send_word(REQ_TICK, 4'd0, 32'd0, 16'd1, 16'd1);
        send_word(REQ_LOAD, 4'd0, 32'd1, 16'd3, 16'd2);
        send_word(REQ_LOAD, 4'd1, 32'd1, 16'd3, 16'd1);
        send_word(REQ_LOAD, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_word(REQ_LOAD, 4'd2, 32'd2, 16'd1, 16'd5);
        send_word(REQ_LOAD, 4'd3, 32'd0, 16'd0, 16'd0);
        repeat (8) send_tick();
        send_word(REQ_LOAD, 4'd2, 32'd12, 16'd2, 16'd0);
        send_word(REQ_LOAD, 4'd4, 32'd10, 16'd65535, 16'd65535);
        repeat (6) send_tick();
        // Pause until every result is back.
        drain_results();
    endtask

    // Random: mostly ticks over tasks arriving near the current time.
    task automatic test_random(int n);
        logic [31:0] arr;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 20)
            begin
                case ($urandom_range(3))
                    0: arr = $urandom;
                    default: arr = now_tick + $urandom_range(6);
                endcase
                send_word(REQ_LOAD, 4'($urandom), arr,
                          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12)),
                          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)));
            end
            else
                send_tick();
        end
    endtask

    // Run with the sender and receiver idling at a given rate.
    task automatic test_idle_phase(int sp, int rp, int n);
        send_idle_pct = sp;
        stall_pct     = rp;
        test_random(n);
        drain_results();
    endtask

    initial
    begin
        errors        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_LOAD;
        slot          = '0;
        task_arrival  = '0;
        task_period   = '0;
        task_burst    = '0;
        out_stall     = 1'b0;
        now_tick      = '0;
        still_running = 1'b0;
        busy_count    = '0;
        for (int i = 0; i < edf_pkg::MAX_TASKS; i++)
        begin
            task_live[i] = 1'b0;
            miss_cnt[i]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idle_phase(0, 0, 420);
        test_idle_phase(54, 0, 420);
        test_idle_phase(0, 54, 420);
        test_idle_phase(27, 27, 420);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
